@@ rtl/core/hdlc_dfr_pkg.sv @@
// Package: shared types, constants and the CRC byte update for the HDLC deframer.
`default_nettype none

package hdlc_dfr_pkg;

  localparam int unsigned WordBitsDef = 16;
  localparam int unsigned ChunkBits   = 8;
  localparam int unsigned ChunkRes    = 2;
  localparam int unsigned NbW         = $clog2(ChunkBits + 1);
  localparam int unsigned CntW        = 10;
  localparam int unsigned ApbAddrW    = 3;
  localparam int unsigned ApbDataW    = 32;

  localparam logic [CntW-1:0] MaxFrameRst = 10'd512;
  localparam logic [0:0]      RegMaxFrame = 1'b0;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'h8408;
  localparam logic [15:0] CrcGood = 16'hF0B8;

  localparam logic [16:0] AbortMask = 17'h1FC00;
  localparam logic [16:0] FlagMask  = 17'h1FE00;
  localparam logic [16:0] FlagPat   = 17'h0FC00;
  localparam logic [16:0] StuffMask = 17'h1F800;
  localparam logic [16:0] StuffPat  = 17'h0F800;

  typedef enum logic [2:0] {
    StGood     = 3'd0,
    StCrcErr   = 3'd1,
    StShort    = 3'd2,
    StAbort    = 3'd3,
    StOverflow = 3'd4
  } frame_status_e;

  typedef enum logic {
    KindData = 1'b0,
    KindEnd  = 1'b1
  } result_kind_e;

  typedef struct packed {
    result_kind_e  kind;
    logic [7:0]    data;
    frame_status_e status;
    logic [CntW-1:0] count;
    logic          last;
  } result_t;

  typedef struct packed {
    logic [16:0]     hist;
    logic [7:0]      shift;
    logic [2:0]      nbits;
    logic            in_frame;
    logic [CntW-1:0] count;
    logic [15:0]     crc;
  } dfr_state_t;

  // Reflected CRC-16/CCITT over one byte; pure XOR network after synthesis.
  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/hdlc_dfr_if.sv @@
// Interfaces: input word channel and result channel of the HDLC deframer.
`default_nettype none

interface hdlc_dfr_word_if #(
  parameter int unsigned WORD_BITS = hdlc_dfr_pkg::WordBitsDef
);
  logic                 valid;
  logic                 ready;
  logic [WORD_BITS-1:0] rx_word;

  modport source (output valid, output rx_word, input ready);
  modport sink   (input valid, input rx_word, output ready);
endinterface

interface hdlc_dfr_res_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic [7:0] data_byte;
  logic [2:0] frame_status;
  logic [9:0] frame_bytes;
  logic       last_of_input;

  modport source (output valid, output result_kind, output data_byte, output frame_status,
                  output frame_bytes, output last_of_input, input ready);
  modport sink   (input valid, input result_kind, input data_byte, input frame_status,
                  input frame_bytes, input last_of_input, output ready);
endinterface

`default_nettype wire

@@ rtl/core/hdlc_dfr_scan.sv @@
// Chunk scanner: abort, flag and stuffing detection, byte packing and CRC over one chunk.
`default_nettype none

module hdlc_dfr_scan (
  input  hdlc_dfr_pkg::dfr_state_t                 state_i,
  input  logic [hdlc_dfr_pkg::ChunkBits-1:0]       bits_i,
  input  logic [hdlc_dfr_pkg::NbW-1:0]             nbits_i,
  input  logic [hdlc_dfr_pkg::CntW-1:0]            max_bytes_i,
  output hdlc_dfr_pkg::dfr_state_t                 state_o,
  output hdlc_dfr_pkg::result_t                    res_o [hdlc_dfr_pkg::ChunkRes],
  output logic [1:0]                               nres_o
);
  import hdlc_dfr_pkg::*;

  dfr_state_t    st;
  result_t       res [ChunkRes];
  logic [1:0]    nres;
  logic          b;
  frame_status_e cst;

  function automatic result_t end_res(frame_status_e s, logic [CntW-1:0] n);
    result_t r;
    r        = '0;
    r.kind   = KindEnd;
    r.status = s;
    r.count  = n;
    return r;
  endfunction

  always_comb begin
    st   = state_i;
    nres = 2'd0;
    b    = 1'b0;
    cst  = StGood;
    for (int j = 0; j < ChunkRes; j++) begin
      res[j] = '0;
    end
    // Walk the line bits oldest first; at most one byte and one frame end per chunk.
    for (int k = 0; k < ChunkBits; k++) begin
      if (NbW'(k) < nbits_i) begin
        b       = bits_i[k];
        st.hist = {b, st.hist[16:1]};
        if ((st.hist & AbortMask) == AbortMask) begin
          if (st.in_frame && (st.count != '0) && (nres < 2'd2)) begin
            res[nres[0]] = end_res(StAbort, st.count);
            nres         = nres + 2'd1;
          end
          st.in_frame = 1'b0;
        end else if ((st.hist & FlagMask) == FlagPat) begin
          if (st.in_frame && (st.count != '0)) begin
            if (st.count < CntW'(4)) begin
              cst = StShort;
            end else if (st.crc == CrcGood) begin
              cst = StGood;
            end else begin
              cst = StCrcErr;
            end
            if (nres < 2'd2) begin
              res[nres[0]] = end_res(cst, st.count);
              nres         = nres + 2'd1;
            end
          end
          st.in_frame = 1'b1;
          st.count    = '0;
          st.crc      = CrcInit;
          st.shift    = '0;
          st.nbits    = '0;
        end else if ((st.hist & StuffMask) == StuffPat) begin
          // drop the stuffed zero
        end else if (st.in_frame) begin
          st.shift = {b, st.shift[7:1]};
          if (st.nbits == 3'd7) begin
            st.nbits = 3'd0;
            if (st.count >= max_bytes_i) begin
              if (nres < 2'd2) begin
                res[nres[0]] = end_res(StOverflow, st.count);
                nres         = nres + 2'd1;
              end
              st.in_frame = 1'b0;
            end else begin
              if (nres < 2'd2) begin
                res[nres[0]]      = '0;
                res[nres[0]].kind = KindData;
                res[nres[0]].data = st.shift;
                nres              = nres + 2'd1;
              end
              st.count = st.count + CntW'(1);
              st.crc   = crc_byte(st.crc, st.shift);
            end
          end else begin
            st.nbits = st.nbits + 3'd1;
          end
        end
      end
    end
  end

  assign state_o = st;
  assign res_o   = res;
  assign nres_o  = nres;

endmodule

`default_nettype wire

@@ rtl/core/hdlc_dfr_obuf.sv @@
// Output buffer: holds the results of one word and hands them out one per cycle while the receiver is ready.
`default_nettype none

module hdlc_dfr_obuf #(
  parameter int unsigned MAX_RES = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  logic [$clog2(MAX_RES+1)-1:0]  push_cnt_i,
  input  hdlc_dfr_pkg::result_t         push_ent_i [MAX_RES],
  output logic                          free_o,
  hdlc_dfr_res_if.source                res_o
);
  import hdlc_dfr_pkg::*;

  localparam int unsigned RcW  = $clog2(MAX_RES + 1);
  localparam int unsigned IdxW = $clog2(MAX_RES);

  result_t         ent_q [MAX_RES];
  logic [RcW-1:0]  cnt_q;
  logic [IdxW-1:0] rd_q;
  result_t         head;
  logic            take;
  logic            drain_last;

  assign head       = ent_q[rd_q];
  assign take       = res_o.valid && res_o.ready;
  assign drain_last = take && ((RcW'(rd_q) + RcW'(1)) == cnt_q);
  assign free_o     = (cnt_q == '0) || drain_last;

  assign res_o.valid         = (cnt_q != '0);
  assign res_o.result_kind   = logic'(head.kind);
  assign res_o.data_byte     = head.data;
  assign res_o.frame_status  = 3'(head.status);
  assign res_o.frame_bytes   = head.count;
  assign res_o.last_of_input = head.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= '0;
    end else if (push_i) begin
      cnt_q <= push_cnt_i;
      rd_q  <= '0;
    end else if (drain_last) begin
      cnt_q <= '0;
      rd_q  <= '0;
    end else if (take) begin
      rd_q <= rd_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q <= push_ent_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/hdlc_deframer_crc_check.sv @@
// Top level: HDLC receive deframer with CRC-16/CCITT frame check.
//
//   channel  | dir | handshake        | payload
//   ---------+-----+------------------+------------------------------------------------
//   rx_i     | in  | valid / ready    | rx_word, WORD_BITS line bits, bit 0 oldest
//   res_o    | out | valid / ready    | result_kind, data_byte, frame_status,
//            |     |                  | frame_bytes, last_of_input
//   apb      | in  | psel/penable     | max_frame_bytes at byte address 0
//
// A word is scanned 8 line bits per cycle, unless its last chunk is stalled, and the next
// word is taken in the last scan cycle. Results leave the output buffer one per cycle while
// the receiver is ready. A word that ends with results waits in its last scan cycle until
// the output buffer is free; a stalled output never blocks earlier scan cycles.
// Reset clears all control and deframer state at once; no clearing pass is needed.
`default_nettype none

module hdlc_deframer_crc_check #(
  parameter int unsigned WORD_BITS = hdlc_dfr_pkg::WordBitsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  hdlc_dfr_word_if.sink                       rx_i,
  hdlc_dfr_res_if.source                      res_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [hdlc_dfr_pkg::ApbAddrW-1:0]   paddr,
  input  logic [hdlc_dfr_pkg::ApbDataW-1:0]   pwdata,
  output logic [hdlc_dfr_pkg::ApbDataW-1:0]   prdata,
  output logic                                pready
);
  import hdlc_dfr_pkg::*;

  localparam int unsigned NChunk   = (WORD_BITS + ChunkBits - 1) / ChunkBits;
  localparam int unsigned MaxRes   = ChunkRes * NChunk;
  localparam int unsigned RcW      = $clog2(MaxRes + 1);
  localparam int unsigned IdxW     = $clog2(MaxRes);
  localparam int unsigned ChW      = (NChunk > 1) ? $clog2(NChunk) : 1;
  localparam int unsigned PadW     = NChunk * ChunkBits;
  localparam int unsigned LastBits = WORD_BITS - (NChunk - 1) * ChunkBits;

  // Configuration register
  logic [CntW-1:0] max_q;
  logic            cfg_wr;

  // Word register and scan control
  logic [WORD_BITS-1:0] w_q;
  logic                 busy_q;
  logic [ChW-1:0]       chunk_q;
  logic [PadW-1:0]      w_pad;
  logic [ChunkBits-1:0] chunk_bits;
  logic [NbW-1:0]       chunk_nbits;
  logic                 last_chunk;
  logic                 word_end;
  logic                 stall;
  logic                 step;
  logic                 accept;

  // Deframer state
  dfr_state_t state_q;
  dfr_state_t scan_state;
  result_t    scan_res [ChunkRes];
  logic [1:0] scan_nres;

  // Result staging for the word in progress
  result_t         stg_q [MaxRes];
  result_t         stg_d [MaxRes];
  logic [RcW-1:0]  stg_cnt_q;
  logic [RcW-1:0]  total;
  logic [IdxW-1:0] wr_idx;
  result_t         push_ent [MaxRes];
  logic            push;
  logic            ob_free;

  // APB: single register, writes complete in the access phase.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == RegMaxFrame);
  assign prdata = (paddr[2] == RegMaxFrame) ? ApbDataW'(max_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= MaxFrameRst;
    end else if (cfg_wr) begin
      max_q <= pwdata[CntW-1:0];
    end
  end

  // Pick the chunk of line bits for this cycle; the last chunk may be short.
  assign w_pad       = PadW'(w_q);
  assign chunk_bits  = w_pad[chunk_q * ChunkBits +: ChunkBits];
  assign last_chunk  = (chunk_q == ChW'(NChunk - 1));
  assign chunk_nbits = last_chunk ? NbW'(LastBits) : NbW'(ChunkBits);

  hdlc_dfr_scan u_scan (
    .state_i     (state_q),
    .bits_i      (chunk_bits),
    .nbits_i     (chunk_nbits),
    .max_bytes_i (max_q),
    .state_o     (scan_state),
    .res_o       (scan_res),
    .nres_o      (scan_nres)
  );

  // Append this chunk's results behind those of earlier chunks.
  always_comb begin
    stg_d  = stg_q;
    wr_idx = '0;
    for (int j = 0; j < ChunkRes; j++) begin
      wr_idx = IdxW'(stg_cnt_q) + IdxW'(j);
      if (2'(j) < scan_nres) begin
        stg_d[wr_idx] = scan_res[j];
      end
    end
    total = stg_cnt_q + RcW'(scan_nres);
  end

  // Flag the final result of the word on its way to the output buffer.
  always_comb begin
    push_ent = stg_d;
    if (total != '0) begin
      push_ent[IdxW'(total - RcW'(1))].last = 1'b1;
    end
  end

  // Hold the last chunk until the output buffer can take the word's results.
  assign word_end    = busy_q && last_chunk;
  assign stall       = word_end && (total != '0) && !ob_free;
  assign push        = word_end && (total != '0) && ob_free;
  assign step        = busy_q && !stall;
  assign rx_i.ready  = !busy_q || (word_end && !stall);
  assign accept      = rx_i.valid && rx_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q         <= 1'b0;
      chunk_q        <= '0;
      stg_cnt_q      <= '0;
      state_q.hist     <= '0;
      state_q.shift    <= '0;
      state_q.nbits    <= '0;
      state_q.in_frame <= 1'b0;
      state_q.count    <= '0;
      state_q.crc      <= CrcInit;
    end else begin
      if (step) begin
        state_q <= scan_state;
        if (word_end) begin
          stg_cnt_q <= '0;
        end else begin
          stg_cnt_q <= total;
          chunk_q   <= chunk_q + ChW'(1);
        end
      end
      if (accept) begin
        busy_q  <= 1'b1;
        chunk_q <= '0;
      end else if (step && word_end) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      w_q <= rx_i.rx_word;
    end
    if (step && !word_end) begin
      stg_q <= stg_d;
    end
  end

  hdlc_dfr_obuf #(
    .MAX_RES (MaxRes)
  ) u_obuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cnt_i (total),
    .push_ent_i (push_ent),
    .free_o     (ob_free),
    .res_o      (res_o)
  );

`ifndef SYNTHESIS
  a_stage_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stg_cnt_q <= RcW'(MaxRes))
    else $error("result staging count exceeds its capacity");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (busy_q && (chunk_q == '0) && (stg_cnt_q == '0)))
    else $error("accepted word does not start a fresh scan");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall |=> (busy_q && $stable(state_q) && $stable(chunk_q)))
    else $error("deframer state moved while the word end was stalled");

  a_chunk_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (chunk_q <= ChW'(NChunk - 1)))
    else $error("chunk counter past the last chunk");
`endif

endmodule

`default_nettype wire

@@ tb/hdlc_deframer_crc_check_tb.sv @@
// Testbench for the HDLC deframer: directed and random line words checked against a predictor.
`default_nettype none

module hdlc_deframer_crc_check_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hdlc_dfr_pkg::*;

  localparam int unsigned LineBits   = 16;
  localparam int unsigned MaxPerWord = 4;
  localparam int unsigned PhaseWords = 44;
  localparam int unsigned IdleCycles = 12;
  localparam int unsigned LongHold   = 300;
  localparam int unsigned CycleLimit = 200000;

  localparam result_t NoRes = '0;

  // One directed row: the line word plus, where it is obvious, the results typed in.
  // typed_n < 0 means the predictor supplies the expected results.
  typedef struct {
    logic [LineBits-1:0] word;
    int                  typed_n;
    result_t             typed0;
    result_t             typed1;
  } stim_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  hdlc_dfr_word_if #(.WORD_BITS(LineBits)) wif ();
  hdlc_dfr_res_if                          rif ();

  hdlc_deframer_crc_check #(.WORD_BITS(LineBits)) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rx_i    (wif),
    .res_o   (rif),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #1 clk_i = ~clk_i;

  // Predictor state: a private copy of the deframer
  logic [16:0]     line_hist;
  logic [7:0]      byte_sr;
  logic [2:0]      byte_bits;
  logic            frame_open;
  logic [CntW-1:0] frame_len;
  logic [15:0]     frame_crc;
  logic [CntW-1:0] max_frame;

  result_t   word_res[$];         // results of the word just deframed
  result_t   pending_results[$];  // expected results, oldest first
  stim_row_t word_notes[$];       // one note per offered word, popped on acceptance

  // Line bit generator
  bit line_bits[$];
  int ones_run;

  int     n_errors;
  int     words_sent;
  int     n_data;
  int     n_ends[5];
  int     cycles;
  bit     calm;      // no idling on either side
  bit     hold_req;  // ask the receiver for one long hold-off

  // Reflected CRC-16/CCITT update by one byte, bit serial
  function automatic logic [15:0] fcs_update(logic [15:0] c, logic [7:0] b);
    logic [15:0] r;
    r = c;
    for (int k = 0; k < 8; k++) begin
      if (r[0] ^ b[k]) r = (r >> 1) ^ CrcPoly;
      else r = r >> 1;
    end
    return r;
  endfunction

  function automatic result_t mk_data(logic [7:0] b, logic last);
    result_t r;
    r = '0;
    r.kind = KindData;
    r.data = b;
    r.last = last;
    return r;
  endfunction

  function automatic result_t mk_end(frame_status_e st, logic [CntW-1:0] n);
    result_t r;
    r = '0;
    r.kind   = KindEnd;
    r.status = st;
    r.count  = n;
    r.last   = 1'b1;
    return r;
  endfunction

  // Drop anything beyond the per-word result limit
  function automatic void emit(result_t r);
    r.last = 1'b0;
    if (word_res.size() < MaxPerWord) word_res.push_back(r);
  endfunction

  // Deframe one line word, oldest bit first, and collect its results in word_res
  function automatic void deframe_word(logic [LineBits-1:0] w);
    frame_status_e st;
    word_res.delete();
    for (int i = 0; i < LineBits; i++) begin
      line_hist = {w[i], line_hist[16:1]};
      if ((line_hist & AbortMask) == AbortMask) begin
        // seven ones: end a frame that holds bytes, then hunt
        if (frame_open && frame_len != 0) emit(mk_end(StAbort, frame_len));
        frame_open = 1'b0;
      end else if ((line_hist & FlagMask) == FlagPat) begin
        if (frame_open && frame_len != 0) begin
          if (frame_len < 4) st = StShort;
          else if (frame_crc == CrcGood) st = StGood;
          else st = StCrcErr;
          emit(mk_end(st, frame_len));
        end
        // every flag opens a fresh, empty frame; drop partial bits
        frame_open = 1'b1;
        frame_len  = '0;
        frame_crc  = CrcInit;
        byte_sr    = '0;
        byte_bits  = '0;
      end else if ((line_hist & StuffMask) == StuffPat) begin
        // stuffed zero: drop
      end else if (frame_open) begin
        byte_sr = {w[i], byte_sr[7:1]};
        if (byte_bits == 3'd7) begin
          byte_bits = '0;
          if (frame_len >= max_frame) begin
            emit(mk_end(StOverflow, frame_len));
            frame_open = 1'b0;
          end else begin
            emit(mk_data(byte_sr, 1'b0));
            frame_len = frame_len + 1'b1;
            frame_crc = fcs_update(frame_crc, byte_sr);
          end
        end else begin
          byte_bits = byte_bits + 1'b1;
        end
      end
    end
    if (word_res.size() != 0) word_res[word_res.size()-1].last = 1'b1;
  endfunction

  // Push one data bit, inserting a zero after five ones
  function automatic void put_bit(bit b);
    line_bits.push_back(b);
    if (b) begin
      ones_run++;
      if (ones_run == 5) begin
        line_bits.push_back(1'b0);
        ones_run = 0;
      end
    end else begin
      ones_run = 0;
    end
  endfunction

  function automatic void put_byte(logic [7:0] b);
    for (int k = 0; k < 8; k++) put_bit(b[k]);
  endfunction

  function automatic void put_flag();
    logic [7:0] f;
    f = 8'h7E;
    for (int k = 0; k < 8; k++) line_bits.push_back(f[k]);
    ones_run = 0;
  endfunction

  // Offer one word; bursts of random length with random gaps between them
  int burst_left;
  task automatic send_word(stim_row_t row);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (!calm) gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
    end
    burst_left--;
    @(negedge clk_i);
    if (gap > 0) begin
      wif.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    wif.valid   <= 1'b1;
    wif.rx_word <= row.word;
    word_notes.push_back(row);
    // hold the word until the deframer takes it
    do @(posedge clk_i); while (wif.ready !== 1'b1);
    words_sent++;
  endtask

  // Pack the generated line bits into words and send every whole one
  task automatic send_line_words();
    logic [LineBits-1:0] w;
    while (line_bits.size() >= LineBits) begin
      for (int k = 0; k < LineBits; k++) w[k] = line_bits.pop_front();
      send_word('{w, -1, NoRes, NoRes});
    end
  endtask

  // Wait until every expected result is out, then let the scanner finish
  task automatic wait_idle();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (IdleCycles) @(posedge clk_i);
  endtask

  // Write max_frame_bytes over APB and read it back
  task automatic set_max_frame(logic [CntW-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ApbAddrW'(4 * RegMaxFrame);
    pwdata  <= ApbDataW'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    max_frame = value;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    if (prdata !== ApbDataW'(value)) begin
      $error("prdata: expected %0d, got %0d", value, prdata);
      n_errors++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Receiver: random ready pattern, plus one long hold-off on request
  initial begin
    int run;
    bit level;
    rif.ready = 1'b0;
    run = 0;
    level = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        rif.ready <= 1'b0;
        repeat (LongHold) @(negedge clk_i);
        hold_req = 1'b0;
        run = 0;
      end else begin
        if (run == 0) begin
          if (calm) begin
            level = 1'b1;
            run = 1;
          end else begin
            level = ~level;
            run = level ? $urandom_range(1, 16) : $urandom_range(1, 6);
          end
        end
        run--;
        rif.ready <= level;
      end
    end
  end

  // Check accepted results against the oldest expectation, then predict accepted words
  always @(posedge clk_i) begin
    result_t   want;
    stim_row_t note;
    if (rif.valid === 1'b1 && rif.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: kind %0d data %0h status %0d bytes %0d",
               rif.result_kind, rif.data_byte, rif.frame_status, rif.frame_bytes);
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        if (rif.result_kind !== want.kind) begin
          $error("result_kind: expected %0d, got %0d", want.kind, rif.result_kind);
          n_errors++;
        end
        if (rif.data_byte !== want.data) begin
          $error("data_byte: expected %0h, got %0h", want.data, rif.data_byte);
          n_errors++;
        end
        if (rif.frame_status !== want.status) begin
          $error("frame_status: expected %0d, got %0d", want.status, rif.frame_status);
          n_errors++;
        end
        if (rif.frame_bytes !== want.count) begin
          $error("frame_bytes: expected %0d, got %0d", want.count, rif.frame_bytes);
          n_errors++;
        end
        if (rif.last_of_input !== want.last) begin
          $error("last_of_input: expected %0d, got %0d", want.last, rif.last_of_input);
          n_errors++;
        end
        if (want.kind == KindData) n_data++;
        else n_ends[want.status]++;
      end
    end
    if (wif.valid === 1'b1 && wif.ready === 1'b1) begin
      note = word_notes.pop_front();
      deframe_word(wif.rx_word);
      // typed rows override the predictor; the predictor still advances its state
      if (note.typed_n >= 0) begin
        if (note.typed_n >= 1) pending_results.push_back(note.typed0);
        if (note.typed_n >= 2) pending_results.push_back(note.typed1);
      end else begin
        foreach (word_res[k]) pending_results.push_back(word_res[k]);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    stim_row_t       dir_rows[$];
    logic [7:0]      body[$];
    logic [15:0]     gen_crc;
    logic [CntW-1:0] phase_cfg[6];
    int              sel;
    int              nd;
    int              start_words;

    wif.valid   = 1'b0;
    wif.rx_word = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    calm        = 1'b0;
    hold_req    = 1'b0;
    burst_left  = 0;
    ones_run    = 0;

    // Predictor at reset: hunting, empty history, buffer size at its reset value
    max_frame  = MaxFrameRst;
    line_hist  = '0;
    byte_sr    = '0;
    byte_bits  = '0;
    frame_open = 1'b0;
    frame_len  = '0;
    frame_crc  = CrcInit;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table. Bytes go LSB first, so a word is {second byte, first byte}.
    // Hunting after reset: zeros and ones alike give nothing.
    dir_rows.push_back('{16'h0000, 0, NoRes, NoRes});
    dir_rows.push_back('{16'hFFFF, 0, NoRes, NoRes});
    // Two flags with nothing between open a frame, then two data bytes.
    dir_rows.push_back('{16'h7E7E, 0, NoRes, NoRes});
    dir_rows.push_back('{16'h0055, 2, mk_data(8'h55, 1'b0), mk_data(8'h00, 1'b1)});
    // Closing a two-byte frame: too short.
    dir_rows.push_back('{16'h7E7E, 1, mk_end(StShort, 10'd2), NoRes});
    dir_rows.push_back('{16'h1234, 2, mk_data(8'h34, 1'b0), mk_data(8'h12, 1'b1)});
    // Seven ones abort a frame that holds bytes.
    dir_rows.push_back('{16'hFFFF, 1, mk_end(StAbort, 10'd2), NoRes});
    dir_rows.push_back('{16'h7E7E, -1, NoRes, NoRes});
    // Abort of an empty frame only stops reception; bits are ignored until a flag.
    dir_rows.push_back('{16'hFFFF, 0, NoRes, NoRes});
    dir_rows.push_back('{16'h5A5A, 0, NoRes, NoRes});
    // "123456789" with its FCS: residue check passes.
    dir_rows.push_back('{16'h317E, -1, NoRes, NoRes});
    dir_rows.push_back('{16'h3332, -1, NoRes, NoRes});
    dir_rows.push_back('{16'h3534, -1, NoRes, NoRes});
    dir_rows.push_back('{16'h3736, -1, NoRes, NoRes});
    dir_rows.push_back('{16'h3938, -1, NoRes, NoRes});
    dir_rows.push_back('{16'h906E, -1, NoRes, NoRes});
    dir_rows.push_back('{16'h7E7E, 1, mk_end(StGood, 10'd11), NoRes});
    // Same frame with one byte changed: CRC error.
    dir_rows.push_back('{16'h317E, -1, NoRes, NoRes});
    dir_rows.push_back('{16'h3332, -1, NoRes, NoRes});
    dir_rows.push_back('{16'h3534, -1, NoRes, NoRes});
    dir_rows.push_back('{16'h3736, -1, NoRes, NoRes});
    dir_rows.push_back('{16'h3939, -1, NoRes, NoRes});
    dir_rows.push_back('{16'h906E, -1, NoRes, NoRes});
    dir_rows.push_back('{16'h7E7E, 1, mk_end(StCrcErr, 10'd11), NoRes});
    // Frame not in whole bytes: flag bits complete a byte, then trailing bits drop.
    dir_rows.push_back('{16'h0000, -1, NoRes, NoRes});
    dir_rows.push_back('{16'h03F0, -1, NoRes, NoRes});
    dir_rows.push_back('{16'h7E7E, -1, NoRes, NoRes});

    foreach (dir_rows[k]) send_word(dir_rows[k]);

    // Buffer sizes per phase: reset value, both extremes, a small one, one below range, a random one
    phase_cfg[0] = MaxFrameRst;
    phase_cfg[1] = 10'd4;
    phase_cfg[2] = 10'd1023;
    phase_cfg[3] = CntW'($urandom_range(5, 24));
    phase_cfg[4] = 10'd3;
    phase_cfg[5] = CntW'($urandom_range(4, 1023));

    for (int p = 0; p < 6; p++) begin
      if (p > 0) begin
        wait_idle();
        set_max_frame(phase_cfg[p]);
      end
      calm = (p == 3);
      // stall the receiver long enough to fill the block and back up the input
      if (p == 2) hold_req = 1'b1;
      start_words = words_sent;
      while (words_sent - start_words < PhaseWords) begin
        sel = $urandom_range(0, 99);
        if (sel < 80) begin
          // well-formed frame with FCS; some corrupted, some with trailing bits
          nd = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 30) : $urandom_range(0, 10);
          body.delete();
          gen_crc = CrcInit;
          for (int k = 0; k < nd; k++) begin
            body.push_back(8'($urandom));
            gen_crc = fcs_update(gen_crc, body[k]);
          end
          gen_crc = ~gen_crc;
          body.push_back(gen_crc[7:0]);
          body.push_back(gen_crc[15:8]);
          if (sel >= 55 && sel < 70)
            body[$urandom_range(0, body.size() - 1)] ^= 8'(1 << $urandom_range(0, 7));
          put_flag();
          foreach (body[k]) put_byte(body[k]);
          if (sel >= 70) repeat ($urandom_range(1, 7)) put_bit(1'($urandom));
          put_flag();
        end else if (sel < 88) begin
          // short frame, no FCS
          put_flag();
          repeat ($urandom_range(1, 3)) put_byte(8'($urandom));
          put_flag();
        end else if (sel < 94) begin
          // frame cut off by an abort
          put_flag();
          repeat ($urandom_range(0, 6)) put_byte(8'($urandom));
          repeat ($urandom_range(7, 12)) line_bits.push_back(1'b1);
          ones_run = 0;
        end else if (sel < 97) begin
          // raw line noise
          repeat ($urandom_range(8, 40)) line_bits.push_back(1'($urandom));
          ones_run = 0;
          put_flag();
        end else begin
          repeat ($urandom_range(1, 3)) put_flag();
        end
        send_line_words();
      end
      // pad with mark idle to a word boundary; the block ends up hunting
      repeat (7) line_bits.push_back(1'b1);
      while (line_bits.size() % LineBits != 0) line_bits.push_back(1'b1);
      send_line_words();
      @(negedge clk_i);
      wif.valid <= 1'b0;
    end

    wait_idle();

    $display("Sent %0d words over six buffer sizes (512, 4, 1023, %0d, 3, %0d).",
             words_sent, phase_cfg[3], phase_cfg[5]);
    $display("Checked %0d data bytes; frame ends good %0d, crc %0d, short %0d, abort %0d, ovf %0d.",
             n_data, n_ends[0], n_ends[1], n_ends[2], n_ends[3], n_ends[4]);
    if (n_errors == 0 && word_notes.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
